// File: rtl/mmcio_pkg.sv
// ----------------------------------------------------------------------------
// Console I/O page package
// Shared types and constants for the memory-mapped console I/O page: the
// address map, the bus function codes and the random generator constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mmcio_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [47:0] seed_type;
   typedef logic [1:0]  func_type;

   // Bus function codes.
   localparam func_type FUNC_WRITE = 2'd0;
   localparam func_type FUNC_READ  = 2'd1;
   localparam func_type FUNC_KEY   = 2'd2;

   // Fixed addresses within the I/O page.
   localparam byte_type ADDR_VSYNC  = 8'd18;
   localparam byte_type ADDR_RANDOM = 8'd23;
   localparam byte_type ADDR_KEYS   = 8'd24;
   localparam byte_type ADDR_VIDEO  = 8'd40;

   // Video bytes come out of reset as spaces.
   localparam byte_type CHAR_SPACE = 8'h20;

   // Linear congruential step: seed = seed * LCG_MUL + LCG_ADD, modulo 2^48.
   localparam seed_type LCG_MUL   = 48'h0005_DEEC_E66D;
   localparam seed_type LCG_ADD   = 48'h0000_0000_000B;
   localparam int       MUL_STEPS = 35;
   localparam seed_type MASK48    = 48'hFFFF_FFFF_FFFF;

   // Range state after reset: maximum 255, divisor MASK48 / 256.
   localparam byte_type RESET_MAX     = 8'd255;
   localparam seed_type RESET_DIVISOR = 48'd1099511627775;

   // Quotient bits per restoring division.
   localparam int DIV_STEPS = 48;

endpackage : mmcio_pkg

`default_nettype wire

// File: rtl/mmcio_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcio_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 40
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : mmcio_ram

`default_nettype wire

// File: rtl/memory_mapped_console_io.sv
// ----------------------------------------------------------------------------
// Memory-mapped console I/O page
// An 8-bit I/O page with console video bytes, a key queue, a vsync strobe and
// a 48-bit linear congruential random source with rejection sampling.
//
//   Channel   Ports                                     Transaction when
//   request   start, busy, req_func, req_addr, req_data start high, busy low
//   response  rsp_strobe, rsp_read_data, rsp_vsync_pulse rsp_strobe high
//   config    csr_valid, csr_ready, csr_data            csr_valid and csr_ready
//
// Plain writes, key events, key reads and unmapped accesses answer on the next
// cycle and the block stays ready, so these may follow each other every cycle.
// A video read passes through the S_MEMRD state (registered RAM read), then
// its response is registered. A random read runs per draw 35 multiply steps,
// one add, 48 divide steps and one range check on the one shared 50-bit adder.
// A nonzero write to the random address runs one 48-step divide on that adder.
// Reset is synchronous and needs no clearing pass; the receiver cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module memory_mapped_console_io #(
   parameter int VIDEO_BYTES = 40,
   parameter int KEY_SLOTS   = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  start,
   output logic                       busy,
   input  wire mmcio_pkg::func_type   req_func,
   input  wire mmcio_pkg::byte_type   req_addr,
   input  wire mmcio_pkg::byte_type   req_data,
   // Response channel.
   output logic                       rsp_strobe,
   output mmcio_pkg::byte_type        rsp_read_data,
   output logic                       rsp_vsync_pulse,
   // Configuration channel.
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire mmcio_pkg::seed_type   csr_data
);

   import mmcio_pkg::*;

   localparam int VID_AW = (VIDEO_BYTES > 1) ? $clog2(VIDEO_BYTES) : 1;
   localparam int KEY_AW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
   localparam logic [8:0] VID_END = 9'(int'(ADDR_VIDEO) + VIDEO_BYTES);
   localparam logic [8:0] KEY_END = 9'(int'(ADDR_KEYS) + KEY_SLOTS);

   // Sequencer state codes.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_INC   = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;
   localparam logic [2:0] S_MEMRD = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [5:0]  cnt_ff, cnt_in;
   seed_type    acc_ff, acc_in;
   seed_type    work_ff, work_in;
   logic        set_range_ff, set_range_in;
   seed_type    seed_main_ff, seed_main_in;
   seed_type    seed_spare_ff, seed_spare_in;
   byte_type    range_max_ff, range_max_in;
   seed_type    range_div_ff, range_div_in;
   byte_type    key_ff [KEY_SLOTS];
   byte_type    key_in [KEY_SLOTS];
   logic [VIDEO_BYTES-1:0] vvalid_ff, vvalid_in;
   logic        vhit_ff, vhit_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   byte_type    rsp_data_ff, rsp_data_in;
   logic        rsp_vsync_ff, rsp_vsync_in;

   logic        accept;
   logic        in_video;
   logic        in_keys;
   byte_type    voff;
   byte_type    koff;
   logic [VID_AW-1:0] vidx;
   logic [KEY_AW-1:0] kidx;
   logic        ram_wr_en;
   logic        ram_rd_en;
   byte_type    ram_rd_data;

   // Shared adder/subtractor.
   logic [49:0] op_a;
   logic [49:0] op_b;
   logic        op_sub;
   logic [49:0] sum;
   seed_type    div_operand;
   logic        qbit;
   seed_type    quo_next;
   logic        draw_ok;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = (state_ff == S_IDLE);

   // Address decode.
   assign voff     = req_addr - ADDR_VIDEO;
   assign koff     = req_addr - ADDR_KEYS;
   assign vidx     = voff[VID_AW-1:0];
   assign kidx     = koff[KEY_AW-1:0];
   assign in_video = (req_addr >= ADDR_VIDEO) && ({1'b0, req_addr} < VID_END);
   assign in_keys  = (req_addr >= ADDR_KEYS) && ({1'b0, req_addr} < KEY_END);

   assign ram_wr_en = accept && (req_func == FUNC_WRITE) && in_video;
   assign ram_rd_en = accept && (req_func == FUNC_READ) && in_video;

   mmcio_ram #(
      .WIDTH (8),
      .DEPTH (VIDEO_BYTES)
   ) u_video_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (vidx),
      .wr_data (req_data),
      .rd_en   (ram_rd_en),
      .rd_addr (vidx),
      .rd_data (ram_rd_data)
   );

   // The divisor is either the stored range divisor or range_max + 1.
   assign div_operand = set_range_ff ? {39'd0, {1'b0, range_max_ff} + 9'd1} : range_div_ff;

   // Operand selection for the shared adder.
   always_comb begin
      op_a   = '0;
      op_b   = '0;
      op_sub = 1'b0;
      case (state_ff)
         S_MUL: begin
            op_a = {2'b00, acc_ff[46:0], 1'b0};
            op_b = LCG_MUL[cnt_ff] ? {2'b00, seed_main_ff} : '0;
         end
         S_INC: begin
            op_a = {2'b00, acc_ff};
            op_b = {2'b00, LCG_ADD};
         end
         S_DIV: begin
            op_a   = {1'b0, acc_ff, work_ff[47]};
            op_b   = {2'b00, div_operand};
            op_sub = 1'b1;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   assign sum      = op_a + (op_sub ? ~op_b : op_b) + {49'd0, op_sub};
   assign qbit     = !sum[49];
   assign quo_next = {work_ff[46:0], qbit};
   assign draw_ok  = (work_ff[47:8] == '0) && (work_ff[7:0] <= range_max_ff);

   // Sequencer and next-state logic.
   always_comb begin
      logic found;
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      work_in       = work_ff;
      set_range_in  = set_range_ff;
      seed_main_in  = seed_main_ff;
      seed_spare_in = seed_spare_ff;
      range_max_in  = range_max_ff;
      range_div_in  = range_div_ff;
      key_in        = key_ff;
      vvalid_in     = vvalid_ff;
      vhit_in       = vhit_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = '0;
      rsp_vsync_in  = 1'b0;
      found         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_WRITE: begin
                     rsp_strobe_in = 1'b1;
                     if (in_video) begin
                        vvalid_in[vidx] = 1'b1;
                     end else if (req_addr == ADDR_KEYS) begin
                        // Shift the key queue out by one slot.
                        for (int i = 0; i + 1 < KEY_SLOTS; i++) begin
                           key_in[i] = key_ff[i+1];
                        end
                        key_in[KEY_SLOTS-1] = '0;
                     end else if (req_addr == ADDR_VSYNC) begin
                        rsp_vsync_in = 1'b1;
                     end else if (req_addr == ADDR_RANDOM) begin
                        if (req_data == '0) begin
                           seed_main_in  = seed_spare_ff;
                           seed_spare_in = seed_main_ff;
                        end else begin
                           // New range: divisor = MASK48 / (m + 1), respond when done.
                           rsp_strobe_in = 1'b0;
                           range_max_in  = req_data;
                           set_range_in  = 1'b1;
                           acc_in        = '0;
                           work_in       = MASK48;
                           cnt_in        = 6'(DIV_STEPS - 1);
                           state_in      = S_DIV;
                        end
                     end
                  end
                  FUNC_READ: begin
                     if (in_video) begin
                        vhit_in  = vvalid_ff[vidx];
                        state_in = S_MEMRD;
                     end else if (in_keys) begin
                        rsp_strobe_in = 1'b1;
                        rsp_data_in   = key_ff[kidx];
                     end else if (req_addr == ADDR_RANDOM) begin
                        set_range_in = 1'b0;
                        acc_in       = '0;
                        cnt_in       = 6'(MUL_STEPS - 1);
                        state_in     = S_MUL;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  FUNC_KEY: begin
                     // Fill the first empty slot; drop the key when all are full.
                     rsp_strobe_in = 1'b1;
                     for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (!found && (key_ff[i] == '0)) begin
                           key_in[i] = req_data;
                           found     = 1'b1;
                        end
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
            // A configuration write loads the main seed.
            if (csr_valid) begin
               seed_main_in = csr_data;
            end
         end
         S_MUL: begin
            // One shift-and-add step of seed * LCG_MUL, most significant bit first.
            acc_in = sum[47:0];
            if (cnt_ff == '0) begin
               state_in = S_INC;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_INC: begin
            seed_main_in = sum[47:0];
            work_in      = sum[47:0];
            acc_in       = '0;
            cnt_in       = 6'(DIV_STEPS - 1);
            state_in     = S_DIV;
         end
         S_DIV: begin
            // One restoring division step: keep the difference when it does not borrow.
            acc_in  = qbit ? sum[47:0] : op_a[47:0];
            work_in = quo_next;
            if (cnt_ff == '0) begin
               if (set_range_ff) begin
                  range_div_in  = quo_next;
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_CHECK;
               end
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_CHECK: begin
            // Accept the draw when it is within range, otherwise draw again.
            if (draw_ok) begin
               rsp_strobe_in = 1'b1;
               rsp_data_in   = work_ff[7:0];
               state_in      = S_IDLE;
            end else begin
               acc_in   = '0;
               cnt_in   = 6'(MUL_STEPS - 1);
               state_in = S_MUL;
            end
         end
         S_MEMRD: begin
            // A video byte never written still reads as a space.
            rsp_strobe_in = 1'b1;
            rsp_data_in   = vhit_ff ? ram_rd_data : CHAR_SPACE;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         set_range_ff  <= 1'b0;
         seed_main_ff  <= '0;
         seed_spare_ff <= '0;
         range_max_ff  <= RESET_MAX;
         range_div_ff  <= RESET_DIVISOR;
         vvalid_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_data_ff   <= '0;
         rsp_vsync_ff  <= 1'b0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            key_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         set_range_ff  <= set_range_in;
         seed_main_ff  <= seed_main_in;
         seed_spare_ff <= seed_spare_in;
         range_max_ff  <= range_max_in;
         range_div_ff  <= range_div_in;
         vvalid_ff     <= vvalid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_vsync_ff  <= rsp_vsync_in;
         key_ff        <= key_in;
      end
   end

   // Datapath registers of the shared unit.
   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      work_ff <= work_in;
      vhit_ff <= vhit_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_vsync_pulse = rsp_vsync_ff;

endmodule : memory_mapped_console_io

`default_nettype wire

// File: rtl/mmcio_checker.sv
// ----------------------------------------------------------------------------
// Console I/O page port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mmcio_checker (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                start,
   input wire logic                busy,
   input wire mmcio_pkg::func_type req_func,
   input wire mmcio_pkg::byte_type req_addr,
   input wire logic                rsp_strobe,
   input wire mmcio_pkg::byte_type rsp_read_data,
   input wire logic                rsp_vsync_pulse
);

   import mmcio_pkg::*;

   // A key event answers on the next cycle with an all-zero response.
   a_key_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_KEY)
      |=> (rsp_strobe && rsp_read_data == '0 && !rsp_vsync_pulse))
      else $error("key event transaction not answered with a zero response");

   // A write to the vsync address pulses vsync on the next cycle.
   a_vsync_response: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_func == FUNC_WRITE && req_addr == ADDR_VSYNC)
      |=> (rsp_strobe && rsp_vsync_pulse))
      else $error("vsync write transaction did not pulse vsync");

   // Response fields are zero outside a response.
   a_quiet_outputs: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |-> (rsp_read_data == '0 && !rsp_vsync_pulse))
      else $error("response fields active without a strobe");

   // The block only becomes busy after taking a transaction.
   a_busy_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a started transaction");

   // No response is delivered while a long operation is still running.
   a_no_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("response strobe while busy");

endmodule : mmcio_checker

bind memory_mapped_console_io mmcio_checker u_mmcio_checker (.*);

`default_nettype wire
